// File: rtl/core/hbtm_pkg.sv
// Shared types and constants for the bucketed hash table.
`default_nettype none
package hbtm_pkg;

   localparam int KEY_W       = 32;
   localparam int VAL_W       = 64;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_SORT   = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD,
      ST_DISPATCH,
      ST_INSERT,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SORT_RI,
      ST_SORT_LI,
      ST_SORT_CJ,
      ST_SORT_WI,
      ST_RESP
   } state_type;

endpackage
`default_nettype wire

// File: rtl/core/hbtm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hbtm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/core/hbtm_mod.sv
// Key mod MODULUS by reciprocal multiplication; key, remainder registered.
`default_nettype none
module hbtm_mod
   import hbtm_pkg::*;
#(
   parameter int MODULUS = 13
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [KEY_W-1:0]             key,
   output logic                              done,
   output logic [$clog2(MODULUS)-1:0]        remainder
);

   localparam int R_W    = $clog2(MODULUS);
   localparam int SHIFT  = KEY_W + R_W;
   localparam int MAG_W  = KEY_W + 1;
   localparam int PROD_W = KEY_W + MAG_W;
   // M = ceil(2^SHIFT / MODULUS); its round-up error is below 2^R_W, so
   // (key * M) >> SHIFT is the exact quotient for every key
   localparam logic [MAG_W-1:0] MAGIC =
      MAG_W'(((64'd1 << SHIFT) + 64'(MODULUS) - 64'd1) / 64'(MODULUS));
   localparam logic [R_W-1:0]   MOD_LO = R_W'(MODULUS);

   logic               busy_ff;
   logic               done_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [R_W-1:0]     rem_ff;
   logic [R_W-1:0]     rem_in;
   logic [PROD_W-1:0]  prod;
   logic [R_W-1:0]     quot_lo;

   // remainder < 2^R_W, so key - q*MODULUS only needs its low R_W bits
   always_comb begin
      prod    = PROD_W'(key_ff) * PROD_W'(MAGIC);
      quot_lo = prod[SHIFT +: R_W];
      rem_in  = key_ff[R_W-1:0] - R_W'(quot_lo * MOD_LO);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= start;
         done_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         key_ff <= key;
      end
      if (busy_ff) begin
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// File: rtl/core/bucketed_hash_table_mod13.sv
// Top level: bucketed hash table, key mod BUCKET_COUNT, entries in one RAM.
//
//   channel | ports                                   | handshake
//   req     | req_op, req_lookup_key, req_payload     | req_valid / req_stall
//   rsp     | rsp_status, rsp_found_value             | rsp_valid / rsp_stall
//
// One item at a time; these are its steps from the accepting edge to rsp_valid.
// Insert: mod, bucket base, RAM write, response. Search: mod, bucket base, then
// a RAM read and a key compare per slot until a hit or the last filled slot, at
// most BUCKET_DEPTH slots, then the response. Sort: each bucket in turn is sorted
// in place by ascending key; an empty bucket is passed over. Then the response.
// Reset clears state, rsp_valid and fill counts; entries are written before read.
// The next beat is taken in the cycle after the response loads; a stalled response
// holds in the output register meanwhile, and input stalls while the next one is handled.
`default_nettype none
module bucketed_hash_table_mod13
   import hbtm_pkg::*;
#(
   parameter int BUCKET_COUNT = 13,
   parameter int BUCKET_DEPTH = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [OP_W-1:0]     req_op,
   input  wire logic [KEY_W-1:0]    req_lookup_key,
   input  wire logic [VAL_W-1:0]    req_payload,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [VAL_W-1:0]         rsp_found_value
);

   localparam int SLOT_COUNT = BUCKET_COUNT * BUCKET_DEPTH;
   localparam int ADDR_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int BKT_W      = $clog2(BUCKET_COUNT);
   localparam int SLOT_W     = $clog2(BUCKET_DEPTH + 1);
   localparam int ENTRY_W    = $bits(entry_type);
   localparam logic [SLOT_W-1:0] DEPTH_C  = SLOT_W'(BUCKET_DEPTH);
   localparam logic [BKT_W-1:0]  LAST_BKT = BKT_W'(BUCKET_COUNT - 1);
   localparam logic [ADDR_W-1:0] BD_A     = ADDR_W'(BUCKET_DEPTH);

   state_type          state_ff, state_in;
   logic [OP_W-1:0]    op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VAL_W-1:0]   val_ff;
   logic [BKT_W-1:0]   bkt_ff;
   logic [ADDR_W-1:0]  base_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [SLOT_W-1:0]  j_ff;
   entry_type          hold_ff;
   status_type         res_status_ff;
   logic [VAL_W-1:0]   res_value_ff;
   logic [SLOT_W-1:0]  fill_ff [BUCKET_COUNT];

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [VAL_W-1:0]   rsp_value_ff;

   logic               accept;
   logic               out_free;
   logic [SLOT_W-1:0]  n_cur;
   logic [SLOT_W-1:0]  j_next;
   logic               swap;
   entry_type          rd_entry;
   logic [ENTRY_W-1:0] rd_data;

   logic               mod_start;
   logic               mod_done;
   logic [BKT_W-1:0]   mod_rem;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   entry_type          ram_wr_entry;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign n_cur     = fill_ff[bkt_ff];
   assign j_next    = j_ff + 1'b1;
   assign rd_entry  = entry_type'(rd_data);
   assign swap      = rd_entry.key < hold_ff.key;

   hbtm_mod #(
      .MODULUS (BUCKET_COUNT)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .key       (req_lookup_key),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   hbtm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ENTRY_W'(ram_wr_entry)),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_INSERT, OP_SEARCH: state_in = ST_MOD;
                  OP_SORT:              state_in = ST_SORT_RI;
                  default:              state_in = ST_RESP;
               endcase
            end
         end
         ST_MOD: begin
            if (mod_done) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            state_in = (op_ff == OP_INSERT) ? ST_INSERT : ST_SRCH_RD;
         end
         ST_INSERT: state_in = ST_RESP;
         ST_SRCH_RD: begin
            state_in = (slot_ff >= n_cur) ? ST_RESP : ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            state_in = (rd_entry.key == key_ff) ? ST_RESP : ST_SRCH_RD;
         end
         ST_SORT_RI: begin
            if (slot_ff >= n_cur && bkt_ff == LAST_BKT) state_in = ST_RESP;
            else if (slot_ff < n_cur) state_in = ST_SORT_LI;
         end
         ST_SORT_LI: begin
            state_in = (j_ff >= n_cur) ? ST_SORT_RI : ST_SORT_CJ;
         end
         ST_SORT_CJ: begin
            if (j_next >= n_cur) state_in = ST_SORT_WI;
         end
         ST_SORT_WI: state_in = ST_SORT_RI;
         ST_RESP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs: mod start, RAM ports
   always_comb begin
      mod_start    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = base_ff;
      ram_wr_entry = hold_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = base_ff;
      case (state_ff)
         ST_IDLE: begin
            mod_start = accept && (req_op == OP_INSERT || req_op == OP_SEARCH);
         end
         ST_INSERT: begin
            ram_wr_en          = (n_cur < DEPTH_C);
            ram_wr_addr        = base_ff + ADDR_W'(n_cur);
            ram_wr_entry.key   = key_ff;
            ram_wr_entry.value = val_ff;
         end
         ST_SRCH_RD, ST_SORT_RI: begin
            ram_rd_en   = (slot_ff < n_cur);
            ram_rd_addr = base_ff + ADDR_W'(slot_ff);
         end
         ST_SORT_LI: begin
            ram_rd_en   = (j_ff < n_cur);
            ram_rd_addr = base_ff + ADDR_W'(j_ff);
         end
         ST_SORT_CJ: begin
            // smaller key moves down: old holder goes to slot j
            ram_wr_en   = swap;
            ram_wr_addr = base_ff + ADDR_W'(j_ff);
            ram_rd_en   = (j_next < n_cur);
            ram_rd_addr = base_ff + ADDR_W'(j_next);
         end
         ST_SORT_WI: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = base_ff + ADDR_W'(slot_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < BUCKET_COUNT; b++) begin
            fill_ff[b] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_RESP && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_INSERT && n_cur < DEPTH_C) begin
            fill_ff[bkt_ff] <= n_cur + 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_ff         <= req_op;
               key_ff        <= req_lookup_key;
               val_ff        <= req_payload;
               bkt_ff        <= '0;
               base_ff       <= '0;
               slot_ff       <= '0;
               res_status_ff <= STAT_OK;
               res_value_ff  <= '0;
            end
         end
         ST_MOD: begin
            if (mod_done) bkt_ff <= mod_rem;
         end
         ST_DISPATCH: begin
            base_ff <= ADDR_W'(bkt_ff * BUCKET_DEPTH);
         end
         ST_INSERT: begin
            if (n_cur >= DEPTH_C) res_status_ff <= STAT_FULL;
         end
         ST_SRCH_RD: begin
            if (slot_ff >= n_cur) res_status_ff <= STAT_MISS;
         end
         ST_SRCH_CMP: begin
            if (rd_entry.key == key_ff) res_value_ff <= rd_entry.value;
            else slot_ff <= slot_ff + 1'b1;
         end
         ST_SORT_RI: begin
            if (slot_ff >= n_cur) begin
               bkt_ff  <= bkt_ff + 1'b1;
               base_ff <= base_ff + BD_A;
               slot_ff <= '0;
            end else begin
               j_ff <= slot_ff + 1'b1;
            end
         end
         ST_SORT_LI: begin
            hold_ff <= rd_entry;
            if (j_ff >= n_cur) slot_ff <= slot_ff + 1'b1;
         end
         ST_SORT_CJ: begin
            if (swap) hold_ff <= rd_entry;
            j_ff <= j_next;
         end
         ST_SORT_WI: begin
            slot_ff <= slot_ff + 1'b1;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_status_ff <= res_status_ff;
               rsp_value_ff  <= res_value_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_value_ff;

endmodule
`default_nettype wire
